// ===== rtl/core/eryu_pkg.sv =====
// ----------------------------------------------------------------------------
// eryu_pkg
// constants and the cordic arctangent table for the euler rate / yaw unwrap
// ----------------------------------------------------------------------------
package eryu_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_LEN = 24;

    localparam logic [31:0] DEG2RAD_Q30  = 32'd1199381129;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
    localparam int          HALF_TURN    = 23040;
    localparam int          FULL_TURN    = 46080;
    localparam int          QUARTER_TURN = 11520;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd843314857;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043837;
            5'd3:  r = 32'd133525159;
            5'd4:  r = 32'd67021687;
            5'd5:  r = 32'd33543516;
            5'd6:  r = 32'd16775851;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194283;
            5'd9:  r = 32'd2097149;
            5'd10: r = 32'd1048576;
            5'd11: r = 32'd524288;
            5'd12: r = 32'd262144;
            5'd13: r = 32'd131072;
            5'd14: r = 32'd65536;
            5'd15: r = 32'd32768;
            5'd16: r = 32'd16384;
            5'd17: r = 32'd8192;
            5'd18: r = 32'd4096;
            5'd19: r = 32'd2048;
            5'd20: r = 32'd1024;
            5'd21: r = 32'd512;
            5'd22: r = 32'd256;
            5'd23: r = 32'd128;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/eryu_cordic.sv =====
// ----------------------------------------------------------------------------
// eryu_cordic
// iterative rotation cordic, one micro-rotation per cycle, sin and cos in q30
// ----------------------------------------------------------------------------
module eryu_cordic #(
    parameter int CORDIC_ITERATIONS = eryu_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_angle,   // 1/128 degree
    output logic               o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int NIT = (CORDIC_ITERATIONS < eryu_pkg::ATAN_LEN) ?
                         CORDIC_ITERATIONS : eryu_pkg::ATAN_LEN;

    typedef enum logic [1:0] {S_IDLE, S_ZMUL, S_RUN} t_state;

    t_state             r_state;
    logic [4:0]         r_i;
    logic               r_flip;
    logic signed [17:0] r_a;
    logic signed [32:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic               r_done;

    logic signed [17:0] a0, a1, a2;
    logic               f2;
    logic [17:0]        mag;
    logic [49:0]        prod;
    logic [36:0]        zr;
    logic signed [32:0] dx, dy;

    always_comb begin
        a0 = {i_angle[16], i_angle};
        a1 = a0;
        if (a0 >= 18'sd23040) a1 = a0 - 18'sd46080;
        else if (a0 < -18'sd23040) a1 = a0 + 18'sd46080;
        a2 = a1;
        f2 = 1'b0;
        if (a1 > 18'sd11520) begin
            a2 = a1 - 18'sd23040;
            f2 = 1'b1;
        end else if (a1 < -18'sd11520) begin
            a2 = a1 + 18'sd23040;
            f2 = 1'b1;
        end
        mag  = r_a[17] ? 18'(-r_a) : 18'(r_a);
        prod = {32'd0, mag} * {18'd0, eryu_pkg::DEG2RAD_Q30};
        zr   = 37'((prod + 50'd4096) >> 13);
        dx   = r_y >>> r_i;
        dy   = r_x >>> r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a     <= a2;
                        r_flip  <= f2;
                        r_state <= S_ZMUL;
                    end
                end
                S_ZMUL: begin
                    r_z     <= r_a[17] ? -34'(zr) : 34'(zr);
                    r_x     <= 33'(eryu_pkg::CORDIC_GAIN);
                    r_y     <= '0;
                    r_i     <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - $signed({2'b00, eryu_pkg::atan_q30(r_i)});
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + $signed({2'b00, eryu_pkg::atan_q30(r_i)});
                    end
                    if (r_i == 5'(NIT - 1)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                    r_i <= r_i + 5'd1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_flip ? 32'(-r_y) : 32'(r_y);
    assign o_cos  = r_flip ? 32'(-r_x) : 32'(r_x);

endmodule

// ===== rtl/core/eryu_div.sv =====
// ----------------------------------------------------------------------------
// eryu_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module eryu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_d;
    logic [32:0] sh;

    assign sh = {r_rem[31:0], r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_d    <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (sh >= {1'b0, r_d}) begin
                    r_rem <= sh - {1'b0, r_d};
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/euler_rate_and_yaw_unwrap.sv =====
// ----------------------------------------------------------------------------
// euler_rate_and_yaw_unwrap
// yaw unwrap with turn count, degree to radian conversion and euler rates
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | yaw_deg, pitch_deg, roll_deg, gyro_pitch_body, gyro_yaw_body
// m_axis  | out | yaw_deg_cont, yaw_rad_cont, pitch_rad, roll_rad, rates
//
// one item runs through the two cordic passes and the 64-step divider
// reset clears the turn count, the last yaw and arms the first-sample flag
// not ready while an item is in work; the next item can be taken while a
// result still waits in the output register, and then holds in the last
// step until that result has been taken
// ----------------------------------------------------------------------------
module euler_rate_and_yaw_unwrap #(
    parameter int CORDIC_ITERATIONS = eryu_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // yaw_deg[15:0], pitch_deg[30:16], roll_deg[46:31],
    // gyro_pitch_body[63:47], gyro_yaw_body[80:64], zero pad
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // yaw_deg_continuous[31:0], yaw_rad_continuous[63:32], pitch_rad[78:64],
    // roll_rad[94:79], yaw_rate_earth[112:95], pitch_rate_earth[129:113], pad
    output logic [135:0] m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_UNWRAP, S_MUL, S_CR, S_WR, S_CP, S_WP,
        S_M1, S_M2, S_M3, S_M4, S_DIV, S_WD, S_OUT
    } t_state;

    t_state r_state;
    logic signed [15:0] r_turn, r_last;
    logic               r_first;
    logic signed [15:0] r_yaw, r_roll;
    logic signed [14:0] r_pitch;
    logic signed [16:0] r_gx, r_gz;
    logic signed [31:0] r_sr, r_cr, r_cp;
    logic signed [31:0] r_ydeg;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_num;
    logic [2:0]         r_mi;
    logic [135:0]       r_out;
    logic               r_ovalid;

    // shared multiplier: signed 33 x 33
    logic signed [32:0] n_ma, n_mb;
    logic signed [65:0] mprod;
    logic [31:0]        r_res [3];

    logic        cs_start, cd_done, dv_start, dv_done;
    logic signed [16:0] c_ang;
    logic signed [31:0] c_sin, c_cos;
    logic [63:0] dv_quot;

    eryu_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cs_start), .i_angle(c_ang),
        .o_done(cd_done), .o_sin(c_sin), .o_cos(c_cos)
    );

    logic [63:0] mn;
    logic [31:0] md;
    assign mn = r_num[63] ? 64'(-r_num) : 64'(r_num);
    assign md = r_cp[31] ? 32'(-r_cp) : 32'(r_cp);

    eryu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(mn + 64'(md >> 1)), .i_den(md), .o_done(dv_done), .o_quot(dv_quot)
    );

    assign cs_start = (r_state == S_CR) || (r_state == S_CP);
    assign c_ang    = (r_state == S_CR) ? 17'(r_roll) : 17'(r_pitch);
    assign dv_start = (r_state == S_DIV);

    always_comb begin
        n_ma = '0;
        n_mb = 33'(eryu_pkg::DEG2RAD_Q30);
        unique case (r_mi)
            3'd0: n_ma = 33'(r_ydeg);
            3'd1: n_ma = 33'(r_pitch);
            3'd2: n_ma = 33'(r_roll);
            3'd3: begin n_ma = 33'(r_cr); n_mb = 33'(r_gx); end
            3'd4: begin n_ma = 33'(r_sr); n_mb = 33'(r_gz); end
            3'd5: begin n_ma = 33'(r_sr); n_mb = 33'(r_gx); end
            3'd6: begin n_ma = 33'(r_cr); n_mb = 33'(r_gz); end
            default: n_ma = '0;
        endcase
        mprod = n_ma * n_mb;
    end

    // round(p / 2^30), halves away from zero
    function automatic logic signed [63:0] rnd30(input logic signed [65:0] p);
        logic [65:0] m;
        logic [65:0] q;
        m = p[65] ? 66'(-p) : 66'(p);
        q = (m + 66'd536870912) >> 30;
        return p[65] ? -64'(q) : 64'(q);
    endfunction

    function automatic logic [31:0] sat_w(input logic signed [63:0] v,
                                          input int w);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return 32'(hi);
        if (v < lo) return 32'(lo);
        return 32'(v);
    endfunction

    logic signed [16:0] dyaw;
    assign dyaw = 17'(r_yaw) - 17'(r_last);

    logic signed [63:0] yr;
    logic signed [63:0] pr;
    logic               neg;
    always_comb begin
        neg = r_num[63] != r_cp[31];
        if (r_cp == 0) begin
            yr = (r_num > 0) ? 64'sd131071 : ((r_num < 0) ? -64'sd131072 : 64'sd0);
        end else if (neg) begin
            yr = (dv_quot > 64'd131072) ? -64'sd131072 : -$signed(dv_quot);
        end else begin
            yr = (dv_quot > 64'd131071) ? 64'sd131071 : $signed(dv_quot);
        end
        pr = rnd30(66'(r_acc));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_turn   <= '0;
            r_last   <= '0;
            r_first  <= 1'b1;
            r_ovalid <= 1'b0;
            r_mi     <= '0;
        end else begin
            // in the output step a taken result is replaced by the new one below
            if (r_ovalid && m_axis_tready && (r_state != S_OUT)) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_yaw   <= s_axis_tdata[15:0];
                        r_pitch <= s_axis_tdata[30:16];
                        r_roll  <= s_axis_tdata[46:31];
                        r_gx    <= s_axis_tdata[63:47];
                        r_gz    <= s_axis_tdata[80:64];
                        r_state <= S_UNWRAP;
                    end
                end
                S_UNWRAP: begin
                    logic signed [15:0] t;
                    t = r_turn;
                    if (!r_first) begin
                        if (dyaw > 17'sd23040) begin
                            if (r_turn != -16'sd32768) t = r_turn - 16'sd1;
                        end else if (-dyaw > 17'sd23040) begin
                            if (r_turn != 16'sd32767) t = r_turn + 16'sd1;
                        end
                    end
                    r_turn  <= t;
                    r_first <= 1'b0;
                    r_last  <= r_yaw;
                    r_ydeg  <= 32'(t) * 32'sd46080 + 32'(r_yaw);
                    r_mi    <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_res[r_mi[1:0]] <= sat_w(rnd30(mprod), (r_mi == 3'd0) ? 32 :
                                             ((r_mi == 3'd1) ? 15 : 16));
                    r_mi <= r_mi + 3'd1;
                    if (r_mi == 3'd2) r_state <= S_CR;
                end
                S_CR: r_state <= S_WR;
                S_WR: begin
                    if (cd_done) begin
                        r_sr    <= c_sin;
                        r_cr    <= c_cos;
                        r_state <= S_CP;
                    end
                end
                S_CP: r_state <= S_WP;
                S_WP: begin
                    if (cd_done) begin
                        r_cp    <= c_cos;
                        r_state <= S_M1;
                    end
                end
                S_M1: begin r_acc <= 64'(mprod); r_mi <= 3'd4; r_state <= S_M2; end
                S_M2: begin r_acc <= r_acc - 64'(mprod); r_mi <= 3'd5; r_state <= S_M3; end
                S_M3: begin r_num <= 64'(mprod); r_mi <= 3'd6; r_state <= S_M4; end
                S_M4: begin r_num <= r_num + 64'(mprod); r_state <= S_DIV; end
                S_DIV: r_state <= S_WD;
                S_WD: begin
                    if (dv_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out <= {6'd0, 17'(sat_w(pr, 17)), 18'(yr),
                                  r_res[2][15:0], r_res[1][14:0], r_res[0], r_ydeg};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_CP) r_mi <= 3'd3;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNWRAP) |=> !r_first) else $error("first flag stuck");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule
